[rtl/polar_scan_soft_decoder_defines.svh]
// Assertion macros for the polar SCAN soft decoder.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef POLAR_SCAN_SOFT_DECODER_DEFINES_SVH
`define POLAR_SCAN_SOFT_DECODER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define PSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/psd_pkg.sv]
// Package for the polar SCAN soft decoder: sizes, word types, codes.
// No dependencies.
`timescale 1ns / 1ps

package psd_pkg;

  // code and number format
  localparam int BLOCK_LENGTH = 64;
  localparam int LGN          = $clog2(BLOCK_LENGTH);
  localparam int LLR_WIDTH    = 10;
  localparam int LLR_MAX_I    = (1 << (LLR_WIDTH - 1)) - 1;
  localparam int OUT_WIDTH    = 10;
  localparam int OUT_MAX_I    = 511;
  localparam int ITW          = 4;
  localparam int ITER_RESET   = 2;

  // message store layout: right store holds the even part, then the odd part
  localparam int LDEPTH  = 2 * BLOCK_LENGTH - 1;
  localparam int EDEPTH  = LDEPTH;
  localparam int ODEPTH  = 7 * BLOCK_LENGTH / 2;
  localparam int RDEPTH  = EDEPTH + ODEPTH;
  localparam int ODD_OFF = EDEPTH;
  localparam int LAW     = $clog2(LDEPTH);
  localparam int RAW     = $clog2(RDEPTH);
  localparam int LVW     = $clog2(LGN + 1);

  typedef logic signed [LLR_WIDTH-1:0] psd_llr_t;
  localparam psd_llr_t LLR_MAX = psd_llr_t'(LLR_MAX_I);

  typedef struct packed {
    logic signed [7:0] channel_llr;
    logic              frozen_flag;
    logic              last_in;
  } psd_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] soft_llr;
    logic                        last_out;
  } psd_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_LEFT_RD,
    ST_LEFT_WR,
    ST_RIGHT_RD,
    ST_RIGHT_WR1,
    ST_RIGHT_WR2,
    ST_FRZ_RD,
    ST_FRZ_WR,
    ST_OUT_RD,
    ST_OUT_WR
  } psd_state_e;

  // write data source for the two stores
  typedef enum logic [2:0] {
    WSEL_ZERO,
    WSEL_LOAD,
    WSEL_LEFT,
    WSEL_FRZ_IN,
    WSEL_FIRST,
    WSEL_SECOND,
    WSEL_FRZ_MEM
  } psd_wsel_e;

  typedef struct packed {
    logic [LAW-1:0] l_ra;
    logic [LAW-1:0] l_rb;
    logic           l_we;
    logic [LAW-1:0] l_wa;
    psd_wsel_e      l_wsel;
    logic [RAW-1:0] r_ra;
    logic [RAW-1:0] r_rb;
    logic           r_we;
    logic [RAW-1:0] r_wa;
    psd_wsel_e      r_wsel;
  } psd_mem_cmd_t;

  typedef struct packed {
    logic in_stall;
    logic grp_odd;
    logic out_load;
    logic out_last;
  } psd_stat_t;

endpackage

[rtl/psd_ram.sv]
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module psd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read ports, registered, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/psd_alu.sv]
// Node update logic: min-sum check node and saturating adds.
// Depends on psd_pkg.
`timescale 1ns / 1ps

module psd_alu (
  input  psd_pkg::psd_llr_t            a_i,
  input  psd_pkg::psd_llr_t            b_i,
  input  psd_pkg::psd_llr_t            x_i,
  input  psd_pkg::psd_llr_t            y_i,
  input  logic                         grp_odd_i,
  output psd_pkg::psd_llr_t            left_o,
  output psd_pkg::psd_llr_t            first_o,
  output psd_pkg::psd_llr_t            second_o,
  output logic signed [psd_pkg::OUT_WIDTH-1:0] out_o
);

  // saturating add, maximum is sticky infinity
  function automatic psd_pkg::psd_llr_t sadd(input psd_pkg::psd_llr_t a,
                                             input psd_pkg::psd_llr_t b);
    logic signed [psd_pkg::LLR_WIDTH:0] s;
    s = a + b;
    if (a == psd_pkg::LLR_MAX || b == psd_pkg::LLR_MAX) return psd_pkg::LLR_MAX;
    if (s > psd_pkg::LLR_MAX_I) return psd_pkg::LLR_MAX;
    if (s < -psd_pkg::LLR_MAX_I) return -psd_pkg::LLR_MAX;
    return psd_pkg::LLR_WIDTH'(s);
  endfunction

  // min-sum check node
  function automatic psd_pkg::psd_llr_t fmin(input psd_pkg::psd_llr_t a,
                                             input psd_pkg::psd_llr_t b);
    psd_pkg::psd_llr_t ma;
    psd_pkg::psd_llr_t mb;
    psd_pkg::psd_llr_t m;
    ma = a[psd_pkg::LLR_WIDTH-1] ? -a : a;
    mb = b[psd_pkg::LLR_WIDTH-1] ? -b : b;
    m  = (ma < mb) ? ma : mb;
    return (a[psd_pkg::LLR_WIDTH-1] != b[psd_pkg::LLR_WIDTH-1]) ? -m : m;
  endfunction

  function automatic logic signed [psd_pkg::OUT_WIDTH-1:0] clip_out(
      input psd_pkg::psd_llr_t v);
    int iv;
    iv = int'(v);
    if (iv > psd_pkg::OUT_MAX_I) iv = psd_pkg::OUT_MAX_I;
    if (iv < -psd_pkg::OUT_MAX_I) iv = -psd_pkg::OUT_MAX_I;
    return psd_pkg::OUT_WIDTH'(iv);
  endfunction

  // left node: x is the right message of this level (odd group) or the odd one
  assign left_o = grp_odd_i ? sadd(b_i, fmin(a_i, x_i)) : fmin(a_i, sadd(b_i, x_i));

  // right node pair: x is the even message, y the odd one
  assign first_o  = fmin(x_i, sadd(y_i, b_i));
  assign second_o = sadd(y_i, fmin(x_i, a_i));

  // soft output: channel side plus level-0 right message
  assign out_o = clip_out(sadd(a_i, x_i));

endmodule

[rtl/psd_ctrl.sv]
// Sequencer: clear, load, SCAN schedule and readout over the two stores.
// Depends on psd_pkg.
`timescale 1ns / 1ps

module psd_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_last_i,
  input  logic [psd_pkg::ITW-1:0]    iter_limit_i,
  input  logic                       out_free_i,
  output psd_pkg::psd_mem_cmd_t      cmd_o,
  output psd_pkg::psd_stat_t         stat_o
);

  localparam int N   = psd_pkg::BLOCK_LENGTH;
  localparam int LGN = psd_pkg::LGN;
  localparam int LVW = psd_pkg::LVW;
  localparam int ITW = psd_pkg::ITW;
  localparam int LAW = psd_pkg::LAW;
  localparam int RAW = psd_pkg::RAW;

  psd_pkg::psd_state_e state_q, state_d;
  logic [ITW-1:0] it_q, it_d;
  logic [LGN-1:0] g_q, g_d;
  logic [LVW-1:0] lvl_q, lvl_d;
  logic [LGN-1:0] k_q, k_d;
  logic [LGN-1:0] cnt_q, cnt_d;
  logic [RAW-1:0] clr_q, clr_d;

  logic [LGN-1:0] grp_v;
  logic [LGN-1:0] half_v;
  logic           k_last;
  logic           next_g;
  logic [ITW:0]   it_p1;
  int lvl_i, k_i, grp_i, half_i;

  // even (left/right) address of a level
  function automatic int ev_addr(input int l, input int bit_i);
    return bit_i + 2 * N - ((2 * N) >> l);
  endfunction

  // odd right-message address, offset into the shared right store
  function automatic int od_addr(input int l, input int grp, input int bit_i);
    int base;
    base = (l - 1) << (LGN - 1);
    if (l == LGN) return bit_i + (grp >> 1) + base + psd_pkg::ODD_OFF;
    return bit_i + ((grp - 1) << (LGN - 1 - l)) + base + psd_pkg::ODD_OFF;
  endfunction

  function automatic logic [LGN-1:0] brev(input logic [LGN-1:0] v);
    logic [LGN-1:0] r;
    for (int j = 0; j < LGN; j++) r[j] = v[LGN-1-j];
    return r;
  endfunction

  // lowest level that the left recursion reaches for group g
  function automatic logic [LVW-1:0] start_level(input logic [LGN-1:0] g);
    int lv;
    lv = 1;
    for (int j = LGN - 1; j >= 0; j--) begin
      if (g[j]) lv = LGN - j;
    end
    return LVW'(lv);
  endfunction

  // schedule position decode
  assign lvl_i  = int'(lvl_q);
  assign k_i    = int'(k_q);
  assign grp_v  = g_q >> (LGN - lvl_i);
  assign half_v = grp_v >> 1;
  assign grp_i  = int'(grp_v);
  assign half_i = int'(half_v);
  assign k_last = (k_q == LGN'((1 << (LGN - lvl_i)) - 1));
  assign it_p1  = {1'b0, it_q} + (ITW + 1)'(1);

  // next state and schedule counters
  always_comb begin
    state_d = state_q;
    it_d    = it_q;
    g_d     = g_q;
    lvl_d   = lvl_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    clr_d   = clr_q;
    next_g  = 1'b0;
    unique case (state_q)
      psd_pkg::ST_CLEAR: begin
        clr_d = clr_q + RAW'(1);
        if (clr_q == RAW'(psd_pkg::RDEPTH - 1)) begin
          clr_d   = '0;
          state_d = psd_pkg::ST_LOAD;
        end
      end
      psd_pkg::ST_LOAD: begin
        if (in_valid_i) begin
          cnt_d = cnt_q + LGN'(1);
          if (in_last_i || cnt_q == LGN'(N - 1)) begin
            cnt_d = '0;
            k_d   = '0;
            if (iter_limit_i == '0) begin
              state_d = psd_pkg::ST_OUT_RD;
            end else begin
              it_d    = '0;
              g_d     = '0;
              lvl_d   = start_level('0);
              state_d = psd_pkg::ST_LEFT_RD;
            end
          end
        end
      end
      psd_pkg::ST_LEFT_RD: state_d = psd_pkg::ST_LEFT_WR;
      psd_pkg::ST_LEFT_WR: begin
        if (!k_last) begin
          k_d     = k_q + LGN'(1);
          state_d = psd_pkg::ST_LEFT_RD;
        end else if (lvl_q != LVW'(LGN)) begin
          lvl_d   = lvl_q + LVW'(1);
          k_d     = '0;
          state_d = psd_pkg::ST_LEFT_RD;
        end else if (g_q[0]) begin
          k_d     = '0;
          state_d = psd_pkg::ST_RIGHT_RD;
        end else begin
          state_d = psd_pkg::ST_FRZ_RD;
        end
      end
      psd_pkg::ST_RIGHT_RD:  state_d = psd_pkg::ST_RIGHT_WR1;
      psd_pkg::ST_RIGHT_WR1: state_d = psd_pkg::ST_RIGHT_WR2;
      psd_pkg::ST_RIGHT_WR2: begin
        if (!k_last) begin
          k_d     = k_q + LGN'(1);
          state_d = psd_pkg::ST_RIGHT_RD;
        end else if (half_v[0] && lvl_q > LVW'(1)) begin
          lvl_d   = lvl_q - LVW'(1);
          k_d     = '0;
          state_d = psd_pkg::ST_RIGHT_RD;
        end else begin
          next_g = 1'b1;
        end
      end
      psd_pkg::ST_FRZ_RD: state_d = psd_pkg::ST_FRZ_WR;
      psd_pkg::ST_FRZ_WR: next_g = 1'b1;
      psd_pkg::ST_OUT_RD: state_d = psd_pkg::ST_OUT_WR;
      psd_pkg::ST_OUT_WR: begin
        if (out_free_i) begin
          if (k_q == LGN'(N - 1)) begin
            k_d     = '0;
            clr_d   = '0;
            state_d = psd_pkg::ST_CLEAR;
          end else begin
            k_d     = k_q + LGN'(1);
            state_d = psd_pkg::ST_OUT_RD;
          end
        end
      end
      default: state_d = psd_pkg::ST_CLEAR;
    endcase

    // advance to the next group, iteration or readout
    if (next_g) begin
      k_d = '0;
      if (g_q == LGN'(N - 1)) begin
        if (it_p1 == {1'b0, iter_limit_i}) begin
          state_d = psd_pkg::ST_OUT_RD;
        end else begin
          it_d    = it_p1[ITW-1:0];
          g_d     = '0;
          lvl_d   = start_level('0);
          state_d = psd_pkg::ST_LEFT_RD;
        end
      end else begin
        g_d     = g_q + LGN'(1);
        lvl_d   = start_level(g_q + LGN'(1));
        state_d = psd_pkg::ST_LEFT_RD;
      end
    end
  end

  // memory commands and status
  always_comb begin
    cmd_o        = '0;
    cmd_o.l_wsel = psd_pkg::WSEL_ZERO;
    cmd_o.r_wsel = psd_pkg::WSEL_ZERO;
    stat_o.in_stall = (state_q != psd_pkg::ST_LOAD);
    stat_o.grp_odd  = grp_v[0];
    stat_o.out_load = (state_q == psd_pkg::ST_OUT_WR) && out_free_i;
    stat_o.out_last = (k_q == LGN'(N - 1));
    unique case (state_q)
      psd_pkg::ST_CLEAR: begin
        cmd_o.l_we = (clr_q < RAW'(psd_pkg::LDEPTH));
        cmd_o.l_wa = clr_q[LAW-1:0];
        cmd_o.r_we = 1'b1;
        cmd_o.r_wa = clr_q;
      end
      psd_pkg::ST_LOAD: begin
        cmd_o.l_we   = in_valid_i;
        cmd_o.l_wa   = LAW'(brev(cnt_q));
        cmd_o.l_wsel = psd_pkg::WSEL_LOAD;
        cmd_o.r_we   = in_valid_i && cnt_q[0];
        cmd_o.r_wa   = RAW'(od_addr(LGN, int'(cnt_q), 0));
        cmd_o.r_wsel = psd_pkg::WSEL_FRZ_IN;
      end
      psd_pkg::ST_LEFT_RD, psd_pkg::ST_LEFT_WR: begin
        cmd_o.l_ra = LAW'(ev_addr(lvl_i - 1, 2 * k_i));
        cmd_o.l_rb = LAW'(ev_addr(lvl_i - 1, 2 * k_i + 1));
        cmd_o.r_ra = grp_v[0] ? RAW'(ev_addr(lvl_i, k_i))
                              : RAW'(od_addr(lvl_i, grp_i + 1, k_i));
        cmd_o.l_we   = (state_q == psd_pkg::ST_LEFT_WR);
        cmd_o.l_wa   = LAW'(ev_addr(lvl_i, k_i));
        cmd_o.l_wsel = psd_pkg::WSEL_LEFT;
      end
      psd_pkg::ST_RIGHT_RD, psd_pkg::ST_RIGHT_WR1, psd_pkg::ST_RIGHT_WR2: begin
        cmd_o.l_ra = LAW'(ev_addr(lvl_i - 1, 2 * k_i));
        cmd_o.l_rb = LAW'(ev_addr(lvl_i - 1, 2 * k_i + 1));
        cmd_o.r_ra = RAW'(ev_addr(lvl_i, k_i));
        cmd_o.r_rb = RAW'(od_addr(lvl_i, grp_i, k_i));
        cmd_o.r_we = (state_q != psd_pkg::ST_RIGHT_RD);
        if (state_q == psd_pkg::ST_RIGHT_WR2) begin
          cmd_o.r_wsel = psd_pkg::WSEL_SECOND;
          cmd_o.r_wa   = half_v[0] ? RAW'(od_addr(lvl_i - 1, half_i, 2 * k_i + 1))
                                   : RAW'(ev_addr(lvl_i - 1, 2 * k_i + 1));
        end else begin
          cmd_o.r_wsel = psd_pkg::WSEL_FIRST;
          cmd_o.r_wa   = half_v[0] ? RAW'(od_addr(lvl_i - 1, half_i, 2 * k_i))
                                   : RAW'(ev_addr(lvl_i - 1, 2 * k_i));
        end
      end
      psd_pkg::ST_FRZ_RD, psd_pkg::ST_FRZ_WR: begin
        // frozen flag of this group sits beside its level-0 LLR
        cmd_o.l_ra   = LAW'(brev(g_q));
        cmd_o.r_we   = (state_q == psd_pkg::ST_FRZ_WR);
        cmd_o.r_wa   = RAW'(ev_addr(LGN, 0));
        cmd_o.r_wsel = psd_pkg::WSEL_FRZ_MEM;
      end
      psd_pkg::ST_OUT_RD, psd_pkg::ST_OUT_WR: begin
        cmd_o.l_ra = LAW'(brev(k_q));
        cmd_o.r_ra = RAW'(brev(k_q));
      end
      default: cmd_o.l_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psd_pkg::ST_CLEAR;
      it_q    <= '0;
      g_q     <= '0;
      lvl_q   <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      it_q    <= it_d;
      g_q     <= g_d;
      lvl_q   <= lvl_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
    end
  end

endmodule

[rtl/polar_scan_soft_decoder.sv]
// Top level of the polar SCAN soft decoder: stores, node logic, output register.
// Depends on psd_pkg, psd_ram, psd_alu, psd_ctrl and the defines header.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o / in_word_i. One word per position
//   (channel LLR, frozen flag, last flag) in natural order, one per cycle while
//   in_stall_o is low. A block ends on last_in or after 64 words.
//   Output channel: out_valid_o / out_stall_i / out_word_o. 64 soft LLRs per
//   block in natural order, last_out on the final one; a stall holds the
//   output register and the readout waits on it.
//   Config: cfg_we_i writes iteration_limit (reset 2); write only while idle.
// Schedule at 64 positions:
//   clearing pass after reset and after each block (input stalled), then load;
//   per iteration 384 left nodes, 192 right node pairs and 32 frozen writes,
//   each a read-modify-write through the two message memories; then readout.
`timescale 1ns / 1ps
`include "polar_scan_soft_decoder_defines.svh"

module polar_scan_soft_decoder (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  psd_pkg::psd_in_t        in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output psd_pkg::psd_out_t       out_word_o,
  input  logic                    cfg_we_i,
  input  logic [psd_pkg::ITW-1:0] cfg_wdata_i
);

  localparam int LW = psd_pkg::LLR_WIDTH;

  psd_pkg::psd_mem_cmd_t cmd;
  psd_pkg::psd_stat_t    stat;

  logic [psd_pkg::ITW-1:0] iter_q;
  logic                    ov_q, ov_d;
  psd_pkg::psd_out_t       out_q;
  psd_pkg::psd_llr_t       sec_q;
  logic                    out_free;

  logic [LW:0]       l_wdata, l_rdata_a, l_rdata_b;
  logic [LW-1:0]     r_wdata, r_rdata_a, r_rdata_b;
  psd_pkg::psd_llr_t left_res, first_res, second_res;
  logic signed [psd_pkg::OUT_WIDTH-1:0] out_res;

  // channel LLR into the message range
  function automatic psd_pkg::psd_llr_t sat_in(input logic signed [7:0] v);
    int iv;
    iv = int'(v);
    if (iv > psd_pkg::LLR_MAX_I) iv = psd_pkg::LLR_MAX_I;
    if (iv < -psd_pkg::LLR_MAX_I) iv = -psd_pkg::LLR_MAX_I;
    return psd_pkg::LLR_WIDTH'(iv);
  endfunction

  // iteration count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= psd_pkg::ITW'(psd_pkg::ITER_RESET);
    end else if (cfg_we_i) begin
      iter_q <= cfg_wdata_i;
    end
  end

  assign out_free = !ov_q || !out_stall_i;

  psd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_last_i    (in_word_i.last_in),
    .iter_limit_i (iter_q),
    .out_free_i   (out_free),
    .cmd_o        (cmd),
    .stat_o       (stat)
  );

  // left store: LLR plus frozen flag at level 0
  always_comb begin
    unique case (cmd.l_wsel)
      psd_pkg::WSEL_LOAD: l_wdata = {in_word_i.frozen_flag, sat_in(in_word_i.channel_llr)};
      psd_pkg::WSEL_LEFT: l_wdata = {1'b0, left_res};
      default:            l_wdata = '0;
    endcase
  end

  // right store: even messages then odd messages
  always_comb begin
    unique case (cmd.r_wsel)
      psd_pkg::WSEL_FRZ_IN:  r_wdata = in_word_i.frozen_flag ? psd_pkg::LLR_MAX : '0;
      psd_pkg::WSEL_FIRST:   r_wdata = first_res;
      psd_pkg::WSEL_SECOND:  r_wdata = sec_q;
      psd_pkg::WSEL_FRZ_MEM: r_wdata = l_rdata_a[LW] ? psd_pkg::LLR_MAX : '0;
      default:               r_wdata = '0;
    endcase
  end

  psd_ram #(
    .WIDTH (LW + 1),
    .DEPTH (psd_pkg::LDEPTH)
  ) u_left_ram (
    .clk_i     (clk_i),
    .we_i      (cmd.l_we),
    .waddr_i   (cmd.l_wa),
    .wdata_i   (l_wdata),
    .raddr_a_i (cmd.l_ra),
    .raddr_b_i (cmd.l_rb),
    .rdata_a_o (l_rdata_a),
    .rdata_b_o (l_rdata_b)
  );

  psd_ram #(
    .WIDTH (LW),
    .DEPTH (psd_pkg::RDEPTH)
  ) u_right_ram (
    .clk_i     (clk_i),
    .we_i      (cmd.r_we),
    .waddr_i   (cmd.r_wa),
    .wdata_i   (r_wdata),
    .raddr_a_i (cmd.r_ra),
    .raddr_b_i (cmd.r_rb),
    .rdata_a_o (r_rdata_a),
    .rdata_b_o (r_rdata_b)
  );

  psd_alu u_alu (
    .a_i       (psd_pkg::psd_llr_t'(l_rdata_a[LW-1:0])),
    .b_i       (psd_pkg::psd_llr_t'(l_rdata_b[LW-1:0])),
    .x_i       (psd_pkg::psd_llr_t'(r_rdata_a)),
    .y_i       (psd_pkg::psd_llr_t'(r_rdata_b)),
    .grp_odd_i (stat.grp_odd),
    .left_o    (left_res),
    .first_o   (first_res),
    .second_o  (second_res),
    .out_o     (out_res)
  );

  // second result of a right node pair is registered and written in the cycle after the first
  always_ff @(posedge clk_i) begin
    sec_q <= second_res;
  end

  // output register
  always_comb begin
    ov_d = ov_q && out_stall_i;
    if (stat.out_load) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.out_load) begin
      out_q.soft_llr <= out_res;
      out_q.last_out <= stat.out_last;
    end
  end

  assign in_stall_o  = stat.in_stall;
  assign out_valid_o = ov_q;
  assign out_word_o  = out_q;

  // checks
  `PSD_ASSERT_NOW(a_load_writes, in_valid_i && !in_stall_o, cmd.l_we, "accepted word not stored")
  `PSD_ASSERT_NOW(a_out_free, stat.out_load, !ov_q || !out_stall_i, "output register overwritten")
  `PSD_ASSERT_NEXT(a_clear_after, stat.out_load && stat.out_last, in_stall_o, "input open after block")

endmodule

[bench/polar_scan_soft_decoder_tb.sv]
// Testbench for the polar SCAN soft decoder: directed table, then random blocks.
// Holds its own SCAN predictor; depends on psd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module polar_scan_soft_decoder_tb;

  localparam int  SETTLE_CYC = 400;        // clearing pass plus margin
  localparam int  HOLD_CYC   = 3000;       // long receiver hold-off
  localparam int  RAND_ITEMS = 385;
  localparam longint LIMIT   = 50000000;

  // directed stimulus row; iters < 0 leaves the register alone
  typedef struct {
    int iters;
    int llr;
    bit frz;
    bit lst;
    bit known;
    int exp_llr;
  } dir_row_t;

  typedef struct {
    bit known;
    int exp_llr;
  } typed_exp_t;

  logic              clk_i, rst_ni;
  logic              in_valid_i, in_stall_o;
  psd_pkg::psd_in_t  in_word_i;
  logic              out_valid_o, out_stall_i;
  psd_pkg::psd_out_t out_word_o;
  logic              cfg_we_i;
  logic [psd_pkg::ITW-1:0] cfg_wdata_i;

  polar_scan_soft_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // ---------------- decoder predictor ----------------
  int left_st [psd_pkg::LDEPTH];
  int even_st [psd_pkg::EDEPTH];
  int odd_st  [psd_pkg::ODEPTH];
  bit frz_map [psd_pkg::BLOCK_LENGTH];
  int words_in_block = 0;
  int scan_iters     = psd_pkg::ITER_RESET;

  psd_pkg::psd_out_t soft_queue[$];
  typed_exp_t        typed_queue[$];

  int  errors = 0, words_taken = 0, results_seen = 0, blocks_done = 0;
  bit  quiet = 0, stim_done = 0;
  int  iters_used[16];

  function automatic int sat_llr(int v);
    if (v > psd_pkg::LLR_MAX_I) return psd_pkg::LLR_MAX_I;
    if (v < -psd_pkg::LLR_MAX_I) return -psd_pkg::LLR_MAX_I;
    return v;
  endfunction

  // saturating add, max value is sticky infinity
  function automatic int inf_add(int a, int b);
    if (a == psd_pkg::LLR_MAX_I || b == psd_pkg::LLR_MAX_I) return psd_pkg::LLR_MAX_I;
    return sat_llr(a + b);
  endfunction

  // min-sum check node
  function automatic int check_node(int a, int b);
    int ma, mb, m;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    m  = ma < mb ? ma : mb;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic int even_idx(int level, int b);
    int i;
    i = b + (1 << (psd_pkg::LGN + 1)) - (1 << (psd_pkg::LGN + 1 - level));
    return (i >= 0 && i < psd_pkg::LDEPTH) ? i : 0;
  endfunction

  function automatic int odd_idx(int level, int group, int b);
    int base, i;
    base = (level - 1) << (psd_pkg::LGN - 1);
    if (level == psd_pkg::LGN) i = b + (group >> 1) + base;
    else i = b + ((group - 1) << (psd_pkg::LGN - 1 - level)) + base;
    return (i >= 0 && i < psd_pkg::ODEPTH) ? i : 0;
  endfunction

  function automatic int bit_rev(int v);
    int r;
    r = 0;
    for (int k = 0; k < psd_pkg::LGN; k++) r = (r << 1) | ((v >> k) & 1);
    return r;
  endfunction

  function automatic void left_pass(int level, int group);
    int a, b, sz;
    if (level == 0) return;
    if ((group & 1) == 0) left_pass(level - 1, group >> 1);
    sz = 1 << (psd_pkg::LGN - level);
    for (int k = 0; k < sz; k++) begin
      a = left_st[even_idx(level - 1, 2 * k)];
      b = left_st[even_idx(level - 1, 2 * k + 1)];
      if (group & 1)
        left_st[even_idx(level, k)] =
          inf_add(b, check_node(a, even_st[even_idx(level, k)]));
      else
        left_st[even_idx(level, k)] =
          check_node(a, inf_add(b, odd_st[odd_idx(level, group + 1, k)]));
    end
  endfunction

  function automatic void right_pass(int level, int group);
    int half, sz, o, e, a, b, f1, f2;
    while (level > 0 && (group & 1)) begin
      half = group >> 1;
      sz   = 1 << (psd_pkg::LGN - level);
      for (int k = 0; k < sz; k++) begin
        o  = odd_st[odd_idx(level, group, k)];
        e  = even_st[even_idx(level, k)];
        a  = left_st[even_idx(level - 1, 2 * k)];
        b  = left_st[even_idx(level - 1, 2 * k + 1)];
        f1 = check_node(e, inf_add(o, b));
        f2 = inf_add(o, check_node(e, a));
        if (half & 1) begin
          odd_st[odd_idx(level - 1, half, 2 * k)]     = f1;
          odd_st[odd_idx(level - 1, half, 2 * k + 1)] = f2;
        end else begin
          even_st[even_idx(level - 1, 2 * k)]     = f1;
          even_st[even_idx(level - 1, 2 * k + 1)] = f2;
        end
      end
      if (!(half & 1)) break;
      level -= 1;
      group = half;
    end
  endfunction

  // absorb one accepted word; a finished block queues its soft outputs
  function automatic void absorb_word(psd_pkg::psd_in_t w, typed_exp_t tx);
    static typed_exp_t pos_exp[psd_pkg::BLOCK_LENGTH];
    int r;
    psd_pkg::psd_out_t o;
    if (words_in_block == 0) begin
      foreach (left_st[i]) left_st[i] = 0;
      foreach (even_st[i]) even_st[i] = 0;
      foreach (odd_st[i]) odd_st[i] = 0;
      foreach (frz_map[i]) begin
        frz_map[i] = 0;
        pos_exp[i].known = 0;
      end
    end
    if (words_in_block < psd_pkg::BLOCK_LENGTH) begin
      left_st[even_idx(0, bit_rev(words_in_block))] = sat_llr(int'(w.channel_llr));
      frz_map[words_in_block] = w.frozen_flag;
      pos_exp[words_in_block] = tx;
      words_in_block++;
    end
    if (!w.last_in && words_in_block < psd_pkg::BLOCK_LENGTH) return;

    for (int g = 1; g < psd_pkg::BLOCK_LENGTH; g += 2)
      if (frz_map[g]) odd_st[odd_idx(psd_pkg::LGN, g, 0)] = psd_pkg::LLR_MAX_I;
    for (int it = 0; it < scan_iters; it++)
      for (int g = 0; g < psd_pkg::BLOCK_LENGTH; g++) begin
        left_pass(psd_pkg::LGN, g);
        if (g & 1) right_pass(psd_pkg::LGN, g);
        else even_st[even_idx(psd_pkg::LGN, 0)] = frz_map[g] ? psd_pkg::LLR_MAX_I : 0;
      end
    for (int k = 0; k < psd_pkg::BLOCK_LENGTH; k++)
      left_st[even_idx(0, k)] = inf_add(left_st[even_idx(0, k)], even_st[even_idx(0, k)]);
    for (int k = 0; k < psd_pkg::BLOCK_LENGTH; k++) begin
      r = left_st[even_idx(0, bit_rev(k))];
      if (r > psd_pkg::OUT_MAX_I) r = psd_pkg::OUT_MAX_I;
      if (r < -psd_pkg::OUT_MAX_I) r = -psd_pkg::OUT_MAX_I;
      // hand-typed value wins where the table gives one
      if (pos_exp[k].known) r = pos_exp[k].exp_llr;
      o.soft_llr = psd_pkg::OUT_WIDTH'(r);
      o.last_out = (k == psd_pkg::BLOCK_LENGTH - 1);
      soft_queue.push_back(o);
    end
    iters_used[scan_iters]++;
    blocks_done++;
    words_in_block = 0;
  endfunction

  // ---------------- clock, reset, timeout ----------------
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
  end

  longint cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- monitors ----------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) scan_iters = int'(cfg_wdata_i);
      if (in_valid_i && !in_stall_o) begin
        words_taken++;
        absorb_word(in_word_i, typed_queue.pop_front());
      end
      if (out_valid_o && !out_stall_i) begin
        psd_pkg::psd_out_t e;
        results_seen++;
        if (soft_queue.size() == 0) begin
          errors++;
          $display("%0t unexpected word: got llr %0d last %0b", $time,
                   out_word_o.soft_llr, out_word_o.last_out);
        end else begin
          e = soft_queue.pop_front();
          if (out_word_o.soft_llr !== e.soft_llr) begin
            errors++;
            $display("%0t soft_llr mismatch: expected %0d actual %0d", $time,
                     e.soft_llr, out_word_o.soft_llr);
          end
          if (out_word_o.last_out !== e.last_out) begin
            errors++;
            $display("%0t last_out mismatch: expected %0b actual %0b", $time,
                     e.last_out, out_word_o.last_out);
          end
        end
      end
    end
  end

  // ---------------- receiver ----------------
  initial begin
    bit held;
    held = 0;
    out_stall_i = 0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (!held && results_seen >= 200) begin
        // long hold-off so the decoder backs up into its input
        held = 1;
        out_stall_i <= 1;
        repeat (HOLD_CYC) @(posedge clk_i);
      end else if (quiet) begin
        out_stall_i <= 0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 0;
        repeat ($urandom_range(1, 60)) @(posedge clk_i);
        if ($urandom_range(0, 2) == 0) begin
          out_stall_i <= 1;
          repeat ($urandom_range(1, 19)) @(posedge clk_i);
        end
      end
    end
  end

  // ---------------- sender ----------------
  task automatic send_word(int llr, bit frz, bit lst, bit known, int exp_llr);
    typed_exp_t tx;
    tx.known   = known;
    tx.exp_llr = exp_llr;
    typed_queue.push_back(tx);
    in_valid_i <= 1;
    in_word_i  <= '{channel_llr: llr[7:0], frozen_flag: frz, last_in: lst};
    do @(posedge clk_i); while (in_stall_o);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // register write once every result is out and the clearing pass is over
  task automatic set_iters(int v);
    in_valid_i <= 0;
    // let the monitor take the last accepted word first
    @(posedge clk_i);
    wait (soft_queue.size() == 0 && words_in_block == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= v[psd_pkg::ITW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  dir_row_t dir_table[] = '{
    // zero iterations: output is the loaded LLRs, most negative byte first
    '{0,  -128, 0, 1, 1, -128},
    '{-1,  127, 1, 0, 1,  127},
    '{-1,   -1, 0, 1, 1,   -1},
    // maximum iterations, mixed frozen positions, early last
    '{15,  127, 1, 0, 0, 0},
    '{-1,    0, 1, 0, 0, 0},
    '{-1, -127, 0, 0, 0, 0},
    '{-1,    5, 1, 0, 0, 0},
    '{-1,  -64, 0, 0, 0, 0},
    '{-1,   85, 1, 1, 0, 0},
    // reset count again, frozen odd positions marked infinite
    '{2,    10, 0, 0, 0, 0},
    '{-1,  -20, 1, 0, 0, 0},
    '{-1,   30, 0, 0, 0, 0},
    '{-1,  -40, 1, 0, 0, 0},
    '{-1,   50, 1, 0, 0, 0},
    '{-1,   60, 1, 0, 0, 0},
    '{-1,  -70, 0, 0, 0, 0},
    '{-1,   80, 1, 1, 0, 0},
    // one iteration, all positions frozen in a short block
    '{1,    -3, 1, 0, 0, 0},
    '{-1,  100, 1, 0, 0, 0},
    '{-1, -100, 1, 1, 0, 0}
  };

  initial begin
    int n, len, kind, sent;
    in_valid_i  = 0;
    in_word_i   = '0;
    cfg_we_i    = 0;
    cfg_wdata_i = '0;
    @(posedge clk_i iff rst_ni);

    // directed table
    foreach (dir_table[i]) begin
      if (dir_table[i].iters >= 0) set_iters(dir_table[i].iters);
      send_word(dir_table[i].llr, dir_table[i].frz, dir_table[i].lst,
                dir_table[i].known, dir_table[i].exp_llr);
    end

    // random blocks; first a full block without last, then one ending on last
    sent = 0;
    n = 0;
    while (sent < RAND_ITEMS) begin
      if (n > 1 && $urandom_range(0, 3) == 0)
        set_iters($urandom_range(0, 9) == 0 ? 15 : $urandom_range(0, 3));
      kind = (n < 2) ? n : $urandom_range(0, 9);
      if (kind <= 1 || kind == 9) len = psd_pkg::BLOCK_LENGTH;
      else len = $urandom_range(1, 24);
      for (int k = 0; k < len; k++) begin
        quiet = (sent > RAND_ITEMS - 60);
        send_word($urandom_range(0, 255), $urandom_range(0, 1),
                  (k == len - 1) && kind != 0, 0, 0);
        sent++;
      end
      n++;
    end
    // close any block still open; a full block without last closes by itself
    if (words_in_block != 0) send_word(0, 0, 1, 0, 0);
    in_valid_i <= 0;
    stim_done = 1;
  end

  // ---------------- end of run ----------------
  initial begin
    wait (stim_done);
    // let the monitor take the last accepted word first
    @(posedge clk_i);
    wait (soft_queue.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (soft_queue.size() != 0) begin
      errors++;
      $display("%0t %0d results never arrived", $time, soft_queue.size());
    end
    $display("Run covered %0d input words, %0d blocks, %0d soft outputs.",
             words_taken, blocks_done, results_seen);
    $display("Blocks at 0, 1, 2, 15 iterations: %0d %0d %0d %0d; errors %0d.",
             iters_used[0], iters_used[1], iters_used[2], iters_used[15], errors);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
